// ----- rtl/http_request_stream_parser_assert.svh -----
// assertion macros for the http request stream parser
// expects clk and rst in the scope of each use; no other dependencies
`ifndef HTTP_REQUEST_STREAM_PARSER_ASSERT_SVH
`define HTTP_REQUEST_STREAM_PARSER_ASSERT_SVH

// property that must hold at every edge outside reset
`define HRSP_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define HRSP_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/hrsp_pkg.sv -----
// shared types, codes and per-byte tagging functions of the http request parser
// no dependencies
package hrsp_pkg;

  localparam int MAX_HEADER_COUNT_DEF = 16;

  // parse phases
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;
  localparam logic [2:0] PH_BODY    = 3'd5;
  localparam logic [2:0] PH_SINK    = 3'd6;

  // field classes
  localparam logic [2:0] FC_NONE    = 3'd0;
  localparam logic [2:0] FC_METHOD  = 3'd1;
  localparam logic [2:0] FC_PATH    = 3'd2;
  localparam logic [2:0] FC_VERSION = 3'd3;
  localparam logic [2:0] FC_KEY     = 3'd4;
  localparam logic [2:0] FC_VALUE   = 3'd5;
  localparam logic [2:0] FC_BODY    = 3'd6;

  // result kinds
  localparam logic [2:0] RK_DATA    = 3'd0;
  localparam logic [2:0] RK_RLINE   = 3'd1;
  localparam logic [2:0] RK_COMMIT  = 3'd2;
  localparam logic [2:0] RK_DROP    = 3'd3;
  localparam logic [2:0] RK_END     = 3'd4;

  // end status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_END   = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_class;
    logic [3:0] header_index;
    logic [2:0] result_kind;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       line_empty;
    logic       skipping;
  } prs_t;

  typedef struct packed {
    prs_t s;
    logic emit;
    res_t r;
  } content_ret_t;

  typedef struct packed {
    prs_t s;
    logic emit;
    logic inc;
    res_t r;
  } line_ret_t;

  localparam prs_t PRS_RESET = '{phase: PH_METHOD, line_empty: 1'b1, skipping: 1'b0};

  function automatic res_t mk_data(logic [7:0] b, logic [2:0] cls, logic [3:0] idx);
    res_t r;
    r = '{out_byte: b, field_class: cls, header_index: idx,
          result_kind: RK_DATA, status: ST_OK};
    return r;
  endfunction

  function automatic res_t mk_mark(logic [2:0] kind, logic [3:0] idx, logic [1:0] st);
    res_t r;
    r = '{out_byte: 8'h00, field_class: FC_NONE, header_index: idx,
          result_kind: kind, status: st};
    return r;
  endfunction

  // one content byte in the current phase
  function automatic content_ret_t take_content(prs_t s, logic [7:0] b, logic quiet,
                                                logic [3:0] idx);
    content_ret_t c;
    c.s    = s;
    c.emit = 1'b0;
    c.r    = '0;
    case (s.phase)
      PH_METHOD: begin
        if (b == CH_SPACE) c.s.phase = PH_PATH;
        else begin
          c.emit = 1'b1;
          c.r    = mk_data(b, FC_METHOD, 4'd0);
        end
      end
      PH_PATH: begin
        if (b == CH_SPACE) c.s.phase = PH_VERSION;
        else begin
          c.emit = 1'b1;
          c.r    = mk_data(b, FC_PATH, 4'd0);
        end
      end
      PH_VERSION: begin
        c.emit = 1'b1;
        c.r    = mk_data(b, FC_VERSION, 4'd0);
      end
      PH_KEY: begin
        c.s.line_empty = 1'b0;
        if (b == CH_COLON) begin
          c.s.phase    = PH_VALUE;
          c.s.skipping = 1'b1;
        end else if (!quiet) begin
          c.emit = 1'b1;
          c.r    = mk_data(b, FC_KEY, idx);
        end
      end
      PH_VALUE: begin
        c.s.line_empty = 1'b0;
        if (!(s.skipping && b == CH_SPACE)) begin
          c.s.skipping = 1'b0;
          if (!quiet) begin
            c.emit = 1'b1;
            c.r    = mk_data(b, FC_VALUE, idx);
          end
        end
      end
      PH_BODY: begin
        c.emit = 1'b1;
        c.r    = mk_data(b, FC_BODY, 4'd0);
      end
      default: ;
    endcase
    return c;
  endfunction

  // a complete cr lf in the current phase
  function automatic line_ret_t take_line_end(prs_t s, logic room, logic [3:0] idx);
    line_ret_t l;
    l.s    = s;
    l.emit = 1'b0;
    l.inc  = 1'b0;
    l.r    = '0;
    case (s.phase)
      PH_METHOD, PH_PATH: begin
        l.s.phase = PH_SINK;
      end
      PH_VERSION: begin
        l.emit         = 1'b1;
        l.r            = mk_mark(RK_RLINE, 4'd0, ST_OK);
        l.s.phase      = PH_KEY;
        l.s.line_empty = 1'b1;
      end
      PH_KEY: begin
        if (s.line_empty) l.s.phase = PH_BODY;
        else begin
          l.emit = 1'b1;
          l.r    = mk_mark(RK_DROP, idx, ST_OK);
        end
        l.s.line_empty = 1'b1;
      end
      PH_VALUE: begin
        l.emit = 1'b1;
        if (room) begin
          l.r   = mk_mark(RK_COMMIT, idx, ST_OK);
          l.inc = 1'b1;
        end else begin
          l.r = mk_mark(RK_DROP, idx, ST_OK);
        end
        l.s.phase      = PH_KEY;
        l.s.line_empty = 1'b1;
        l.s.skipping   = 1'b0;
      end
      default: ;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/http_request_stream_parser.sv -----
// top level of the http request stream parser: byte tagging and result queue
// depends on hrsp_pkg and http_request_stream_parser_assert.svh
//
// Takes one request byte per accepted item and returns up to three result items for it
// (tagged content bytes, line markers, end status), last_of_run marking the final one.
// The parse state is updated in the accepting cycle and the item's results land in a
// three-slot result register that drains one result per cycle while out_ready is high;
// a new byte is taken whenever that register is empty or its last result leaves in the
// same cycle. Bytes giving one result so run at one item per clock while out_ready is
// high; an item giving more waits until all but its last leave the single output port.
`include "http_request_stream_parser_assert.svh"

module http_request_stream_parser
  import hrsp_pkg::*;
#(
  parameter int MAX_HEADER_COUNT = MAX_HEADER_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] field_class,
  output logic [3:0] header_index,
  output logic [2:0] result_kind,
  output logic [1:0] status,
  output logic       last_of_run
);

  localparam int HCW = $clog2(MAX_HEADER_COUNT + 1);

  // parse state
  prs_t           st;
  prs_t           st_next;
  logic           cr_pending;
  logic           cr_pending_next;
  logic [HCW-1:0] header_count;
  logic [HCW-1:0] header_count_next;

  // result register
  res_t       slot [3];
  logic [1:0] rem;

  // per-item combinational results
  res_t         slot_new [3];
  logic [1:0]   n_new;
  content_ret_t c_a;
  content_ret_t c_b;
  line_ret_t    l_a;
  prs_t         s_w;
  logic         inc;
  logic         in_hdr;
  logic         quiet;
  logic         room;
  logic [3:0]   idx;
  logic [3:0]   idx_after;
  logic         ended;
  logic [1:0]   end_st;
  logic         in_fire;
  logic         out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // handshake of the result register
  assign in_ready  = (rem == 2'd0) || (rem == 2'd1 && out_ready);
  assign out_valid = (rem != 2'd0);

  assign out_byte     = slot[0].out_byte;
  assign field_class  = slot[0].field_class;
  assign header_index = slot[0].header_index;
  assign result_kind  = slot[0].result_kind;
  assign status       = slot[0].status;
  assign last_of_run  = (rem == 2'd1);

  assign in_hdr    = (st.phase == PH_KEY) || (st.phase == PH_VALUE);
  assign quiet     = last_byte && in_hdr;
  assign room      = header_count < HCW'(MAX_HEADER_COUNT);
  assign idx       = 4'(header_count);

  // tag one byte: held cr first, then the byte itself, then the end of message
  always_comb begin
    s_w             = st;
    cr_pending_next = cr_pending;
    inc             = 1'b0;
    ended           = 1'b0;
    n_new           = 2'd0;
    slot_new[0]     = '0;
    slot_new[1]     = '0;
    slot_new[2]     = '0;
    end_st          = ST_OK;
    c_a             = '0;
    c_b             = '0;
    l_a             = '0;

    if (st.phase == PH_BODY || st.phase == PH_SINK) begin
      c_b = take_content(s_w, in_byte, 1'b0, idx);
      s_w = c_b.s;
      if (c_b.emit) begin
        slot_new[n_new] = c_b.r;
        n_new           = n_new + 2'd1;
      end
    end else begin
      if (cr_pending) begin
        cr_pending_next = 1'b0;
        if (in_byte == CH_LF) begin
          l_a   = take_line_end(s_w, room, idx);
          s_w   = l_a.s;
          inc   = l_a.inc;
          ended = 1'b1;
          if (l_a.emit) begin
            slot_new[n_new] = l_a.r;
            n_new           = n_new + 2'd1;
          end
        end else begin
          c_a = take_content(s_w, CH_CR, quiet, idx);
          s_w = c_a.s;
          if (c_a.emit) begin
            slot_new[n_new] = c_a.r;
            n_new           = n_new + 2'd1;
          end
        end
      end
      if (!ended) begin
        if (in_byte == CH_CR && !last_byte) begin
          cr_pending_next = 1'b1;
        end else begin
          c_b = take_content(s_w, in_byte, quiet, idx);
          s_w = c_b.s;
          if (c_b.emit && n_new != 2'd3) begin
            slot_new[n_new] = c_b.r;
            n_new           = n_new + 2'd1;
          end
        end
      end
    end

    header_count_next = header_count + (inc ? HCW'(1) : HCW'(0));
    idx_after         = 4'(header_count_next);
    st_next           = s_w;

    // end of message: drop an open header line, report status, return to reset
    if (last_byte) begin
      if ((s_w.phase == PH_KEY || s_w.phase == PH_VALUE) && !s_w.line_empty &&
          n_new != 2'd3) begin
        slot_new[n_new] = mk_mark(RK_DROP, idx_after, ST_OK);
        n_new           = n_new + 2'd1;
      end
      if (s_w.phase == PH_METHOD || s_w.phase == PH_PATH || s_w.phase == PH_VERSION)
        end_st = ST_NO_END;
      else if (s_w.phase == PH_SINK)
        end_st = ST_NO_SPACE;
      if (n_new != 2'd3) begin
        slot_new[n_new] = mk_mark(RK_END, 4'd0, end_st);
        n_new           = n_new + 2'd1;
      end
      st_next           = PRS_RESET;
      cr_pending_next   = 1'b0;
      header_count_next = '0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= PRS_RESET;
      cr_pending   <= 1'b0;
      header_count <= '0;
    end else if (in_fire) begin
      st           <= st_next;
      cr_pending   <= cr_pending_next;
      header_count <= header_count_next;
    end
  end

  // result register: load on a new item, shift down as results leave
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (in_fire) begin
      rem <= n_new;
    end else if (out_fire) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot[0] <= slot_new[0];
      slot[1] <= slot_new[1];
      slot[2] <= slot_new[2];
    end else if (out_fire) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  // checks on the parse state and the result register
  `HRSP_ALWAYS(a_cr_in_line, !cr_pending || (st.phase != PH_BODY && st.phase != PH_SINK), "cr held outside a line phase")
  `HRSP_ALWAYS(a_hdr_limit, header_count <= HCW'(MAX_HEADER_COUNT), "header count past limit")
  `HRSP_NEXT(a_msg_reset, in_fire && last_byte, st.phase == PH_METHOD && header_count == '0 && !cr_pending, "parser not reset after final byte")
  `HRSP_ALWAYS(a_no_overrun, !in_fire || rem == 2'd0 || (rem == 2'd1 && out_fire), "item taken over pending results")

endmodule
